// ===== src/cpa_pkg.sv =====
// Shared types and constants for the command priority array.
package cpa_pkg;

   localparam int LEVELS       = 16;
   localparam int LEVEL_W      = $clog2(LEVELS);
   localparam int ACT_W        = $clog2(LEVELS + 1);
   localparam int REQ_W        = 2;
   localparam int PRIO_W       = 5;
   localparam int VALUE_W      = 8;
   localparam int INDEX_W      = 5;
   localparam int DATA_W       = 5;
   localparam int STATUS_W     = 3;
   localparam int ADDR_W       = 3;
   localparam int CSR_W        = 32;
   localparam int DENIED_LEVEL = 6;
   localparam int INDEX_ALL    = 17;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REQ_W-1:0] REQ_WRITE      = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RELINQUISH = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ       = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_FALLBACK_VALUE = 3'd0;
   localparam logic [ADDR_W-1:0] ADDR_NOTIFY_OFF     = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_ARRAY = 3'd1,
      ST_DENIED    = 3'd2,
      ST_RANGE     = 3'd3,
      ST_BAD_INDEX = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_STATUS,
      OP_COUNT,
      OP_READ_ONE,
      OP_READ_ALL,
      OP_WRITE,
      OP_RELINQ
   } op_type;

   typedef struct packed {
      op_type               op;
      status_type           status;
      logic [LEVEL_W-1:0]   level;
      logic                 bit_value;
   } cmd_type;

   typedef enum logic [1:0] {
      EX_IDLE,
      EX_SCAN,
      EX_READ_ALL
   } exec_state_type;

endpackage

// ===== src/command_priority_array.sv =====
// Top level of the command priority array.
//
// A request is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Each result is shown for exactly one
// cycle with rsp_valid high and cannot be held off by the receiver. A write,
// a status-only request, a single-element read or a relinquish of a level
// that is not active passes through the queue and gives its result from the
// executor's response register. A relinquish of the active level walks the
// lower-priority levels one per cycle through the executor's scan counter
// before its result. A whole-array read streams 16 results on consecutive
// cycles, the last one marked by rsp_last. The executor handles one item at a
// time: it pops an item, scans or streams where the item needs it, and only
// then pops the next.
module command_priority_array import cpa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_element_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_present_value,
   output logic                rsp_changed,
   output logic [ACT_W-1:0]    rsp_active_level,
   output logic                rsp_read_is_null,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   logic    full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;
   logic    fallback_value;
   logic    notify_off;

   cpa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .fallback_value (fallback_value),
      .notify_off     (notify_off)
   );

   cpa_front u_front (
      .start             (start),
      .full              (full),
      .req_type          (req_type),
      .req_priority_req  (req_priority_req),
      .req_value         (req_value),
      .req_element_index (req_element_index),
      .busy              (busy),
      .push              (push),
      .cmd               (push_cmd)
   );

   cpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   cpa_exec u_exec (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .fallback_value    (fallback_value),
      .notify_off        (notify_off),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_present_value (rsp_present_value),
      .rsp_changed       (rsp_changed),
      .rsp_active_level  (rsp_active_level),
      .rsp_read_is_null  (rsp_read_is_null),
      .rsp_read_data     (rsp_read_data),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== src/cpa_csr.sv =====
// Configuration register file behind the APB-style port.
module cpa_csr import cpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready,
   output logic              fallback_value,
   output logic              notify_off
);

   logic fallback_value_ff, fallback_value_in;
   logic notify_off_ff, notify_off_in;
   logic wr_en;
   logic rd_bit;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      fallback_value_in = fallback_value_ff;
      notify_off_in     = notify_off_ff;
      if (wr_en) begin
         if (paddr[2] == ADDR_NOTIFY_OFF[2]) begin
            notify_off_in = pwdata[0];
         end else begin
            fallback_value_in = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_value_ff <= 1'b0;
         notify_off_ff     <= 1'b0;
      end else begin
         fallback_value_ff <= fallback_value_in;
         notify_off_ff     <= notify_off_in;
      end
   end

   always_comb begin
      case (paddr)
         ADDR_FALLBACK_VALUE: rd_bit = fallback_value_ff;
         ADDR_NOTIFY_OFF:     rd_bit = notify_off_ff;
         default:             rd_bit = 1'b0;
      endcase
   end

   assign prdata         = {{(CSR_W-1){1'b0}}, rd_bit};
   assign pready         = 1'b1;
   assign fallback_value = fallback_value_ff;
   assign notify_off     = notify_off_ff;

endmodule

// ===== src/cpa_front.sv =====
// Front end: accepts request items and classifies them into commands.
module cpa_front import cpa_pkg::*; (
   input  logic               start,
   input  logic               full,
   input  logic [REQ_W-1:0]   req_type,
   input  logic [PRIO_W-1:0]  req_priority_req,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0] req_element_index,
   output logic               busy,
   output logic               push,
   output cmd_type            cmd
);

   logic [PRIO_W-1:0]  prio_m1;
   logic [INDEX_W-1:0] index_m1;

   assign busy     = full;
   assign push     = start & ~full;
   assign prio_m1  = req_priority_req - PRIO_W'(1);
   assign index_m1 = req_element_index - INDEX_W'(1);

   always_comb begin
      cmd.op        = OP_STATUS;
      cmd.status    = ST_OK;
      cmd.level     = '0;
      cmd.bit_value = req_value[0];
      case (req_type)
         REQ_READ: begin
            if (req_element_index == '0) begin
               cmd.op = OP_COUNT;
            end else if (req_element_index == INDEX_W'(INDEX_ALL)) begin
               cmd.op = OP_READ_ALL;
            end else if (req_element_index > INDEX_W'(LEVELS)) begin
               cmd.status = ST_BAD_INDEX;
            end else begin
               cmd.op    = OP_READ_ONE;
               cmd.level = index_m1[LEVEL_W-1:0];
            end
         end
         REQ_WRITE, REQ_RELINQUISH: begin
            if (req_element_index != INDEX_W'(INDEX_ALL)) begin
               cmd.status = ST_NOT_ARRAY;
            end else if (req_priority_req == PRIO_W'(DENIED_LEVEL)) begin
               cmd.status = ST_DENIED;
            end else if (req_type == REQ_WRITE && req_value > VALUE_W'(1)) begin
               cmd.status = ST_RANGE;
            end else if (req_priority_req == '0
                         || req_priority_req > PRIO_W'(LEVELS)) begin
               cmd.status = ST_OK;
            end else begin
               cmd.op    = (req_type == REQ_WRITE) ? OP_WRITE : OP_RELINQ;
               cmd.level = prio_m1[LEVEL_W-1:0];
            end
         end
         default: begin
            cmd.status = ST_OK;
         end
      endcase
   end

endmodule

// ===== src/cpa_queue.sv =====
// Short command queue between the front end and the executor.
module cpa_queue import cpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/cpa_exec.sv =====
// Executor: holds the priority array, scans levels and drives result items.
module cpa_exec import cpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   input  logic              fallback_value,
   input  logic              notify_off,
   output logic              pop,
   output logic              rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic              rsp_present_value,
   output logic              rsp_changed,
   output logic [ACT_W-1:0]  rsp_active_level,
   output logic              rsp_read_is_null,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_last
);

   exec_state_type      state_ff, state_in;
   logic [ACT_W-1:0]    cnt_ff, cnt_in;
   logic [ACT_W-1:0]    active_ff, active_in;
   logic                present_ff, present_in;
   logic [LEVELS-1:0]   valid_ff, valid_in;
   logic [LEVELS-1:0]   values_ff, values_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_present_ff, rsp_present_in;
   logic                rsp_changed_ff, rsp_changed_in;
   logic [ACT_W-1:0]    rsp_active_ff, rsp_active_in;
   logic                rsp_null_ff, rsp_null_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LEVEL_W-1:0]  rd_addr;
   logic                slot_hit;
   logic                slot_bit;
   logic                scan_end;
   logic                scan_done;
   logic                is_active_level;
   logic                write_takes;
   logic                new_present;

   assign rd_addr         = (state_ff == EX_IDLE) ? head_cmd.level : cnt_ff[LEVEL_W-1:0];
   assign slot_hit        = valid_ff[rd_addr];
   assign slot_bit        = values_ff[rd_addr];
   assign scan_end        = (cnt_ff == ACT_W'(LEVELS));
   assign scan_done       = scan_end | slot_hit;
   assign is_active_level = ({1'b0, head_cmd.level} == active_ff);
   assign write_takes     = ({1'b0, head_cmd.level} <= active_ff);
   assign new_present     = scan_end ? fallback_value : slot_bit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: begin
            if (head_valid) begin
               if (head_cmd.op == OP_READ_ALL) begin
                  state_in = EX_READ_ALL;
               end else if (head_cmd.op == OP_RELINQ && is_active_level) begin
                  state_in = EX_SCAN;
               end
            end
         end
         EX_SCAN: begin
            if (scan_done) begin
               state_in = EX_IDLE;
            end
         end
         EX_READ_ALL: begin
            if (cnt_ff[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1)) begin
               state_in = EX_IDLE;
            end
         end
         default: begin
            state_in = EX_IDLE;
         end
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      cnt_in         = cnt_ff;
      active_in      = active_ff;
      present_in     = present_ff;
      valid_in       = valid_ff;
      values_in      = values_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_present_in = present_ff;
      rsp_changed_in = 1'b0;
      rsp_active_in  = active_ff;
      rsp_null_in    = 1'b0;
      rsp_data_in    = '0;
      rsp_last_in    = 1'b1;
      case (state_ff)
         EX_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               case (head_cmd.op)
                  OP_STATUS: begin
                     rsp_status_in = head_cmd.status;
                  end
                  OP_COUNT: begin
                     rsp_data_in = DATA_W'(LEVELS);
                  end
                  OP_READ_ONE: begin
                     rsp_null_in = ~slot_hit;
                     rsp_data_in = DATA_W'(slot_hit & slot_bit);
                  end
                  OP_READ_ALL: begin
                     rsp_valid_in = 1'b0;
                     cnt_in       = '0;
                  end
                  OP_WRITE: begin
                     values_in[head_cmd.level] = head_cmd.bit_value;
                     valid_in[head_cmd.level]  = 1'b1;
                     if (write_takes) begin
                        active_in      = {1'b0, head_cmd.level};
                        present_in     = head_cmd.bit_value;
                        rsp_active_in  = {1'b0, head_cmd.level};
                        rsp_present_in = head_cmd.bit_value;
                        rsp_changed_in = (present_ff != head_cmd.bit_value)
                                         & ~notify_off;
                     end
                  end
                  OP_RELINQ: begin
                     valid_in[head_cmd.level] = 1'b0;
                     if (is_active_level) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = {1'b0, head_cmd.level} + ACT_W'(1);
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         EX_SCAN: begin
            if (scan_done) begin
               active_in      = cnt_ff;
               present_in     = new_present;
               rsp_valid_in   = 1'b1;
               rsp_active_in  = cnt_ff;
               rsp_present_in = new_present;
               rsp_changed_in = (present_ff != new_present) & ~notify_off;
            end else begin
               cnt_in = cnt_ff + ACT_W'(1);
            end
         end
         EX_READ_ALL: begin
            rsp_valid_in = 1'b1;
            rsp_null_in  = ~slot_hit;
            rsp_data_in  = DATA_W'(slot_hit & slot_bit);
            rsp_last_in  = (cnt_ff[LEVEL_W-1:0] == LEVEL_W'(LEVELS - 1));
            cnt_in       = cnt_ff + ACT_W'(1);
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_IDLE;
         cnt_ff       <= '0;
         active_ff    <= ACT_W'(LEVELS);
         present_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         present_ff   <= present_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      values_ff      <= values_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_null_ff    <= rsp_null_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_present_value = rsp_present_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_active_level  = rsp_active_ff;
   assign rsp_read_is_null  = rsp_null_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== sim/command_priority_array_test.sv =====
// Self-checking testbench for the command priority array: directed table, then random commands.
module command_priority_array_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cpa_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int PRINT_LIMIT = 30;
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int PHASES = 5;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [PRIO_W-1:0]  prio;
      logic [VALUE_W-1:0] val;
      logic [INDEX_W-1:0] idx;
   } command_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                present;
      logic                changed;
      logic [ACT_W-1:0]    active;
      logic                is_null;
      logic [DATA_W-1:0]   data;
      logic                last;
   } array_rsp_t;

   typedef struct packed {
      command_t   cmd;
      bit         typed;
      array_rsp_t exp;
   } table_row_t;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [PRIO_W-1:0]   req_priority_req;
   logic [VALUE_W-1:0]  req_value;
   logic [INDEX_W-1:0]  req_element_index;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_present_value;
   logic                rsp_changed;
   logic [ACT_W-1:0]    rsp_active_level;
   logic                rsp_read_is_null;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_last;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [CSR_W-1:0]    pwdata;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   logic                slot_value [LEVELS];
   logic [LEVELS-1:0]   slot_held;
   logic [ACT_W-1:0]    active_slot;
   logic                present_bit;
   logic                fallback_bit;
   logic                service_off;

   array_rsp_t pending_rsp [$];
   table_row_t directed_rows [$];
   int         mismatch_count;
   bit         no_idle;

   command_priority_array DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_priority_req  (req_priority_req),
      .req_value         (req_value),
      .req_element_index (req_element_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_present_value (rsp_present_value),
      .rsp_changed       (rsp_changed),
      .rsp_active_level  (rsp_active_level),
      .rsp_read_is_null  (rsp_read_is_null),
      .rsp_read_data     (rsp_read_data),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
      end
   endtask

   function automatic array_rsp_t make_rsp(input logic [STATUS_W-1:0] status,
                                           input logic changed, input logic is_null,
                                           input logic [DATA_W-1:0] data, input logic last);
      array_rsp_t r;
      r.status  = status;
      r.present = present_bit;
      r.changed = changed;
      r.active  = active_slot;
      r.is_null = is_null;
      r.data    = data;
      r.last    = last;
      return r;
   endfunction

   task automatic apply_command(input command_t c);
      logic prev;
      int   lvl;
      prev = present_bit;
      lvl  = int'(c.prio) - 1;
      if (c.kind == REQ_READ) begin
         if (c.idx == 0) begin
            pending_rsp.push_back(make_rsp(ST_OK, 1'b0, 1'b0, DATA_W'(LEVELS), 1'b1));
         end else if (c.idx == INDEX_ALL) begin
            for (int i = 0; i < LEVELS; i++) begin
               pending_rsp.push_back(make_rsp(ST_OK, 1'b0, !slot_held[i],
                  slot_held[i] ? DATA_W'(slot_value[i]) : DATA_W'(0), i == LEVELS - 1));
            end
         end else if (c.idx > LEVELS) begin
            pending_rsp.push_back(make_rsp(ST_BAD_INDEX, 1'b0, 1'b0, '0, 1'b1));
         end else if (slot_held[c.idx - 1]) begin
            pending_rsp.push_back(make_rsp(ST_OK, 1'b0, 1'b0,
               DATA_W'(slot_value[c.idx - 1]), 1'b1));
         end else begin
            pending_rsp.push_back(make_rsp(ST_OK, 1'b0, 1'b1, '0, 1'b1));
         end
      end else if (c.kind == REQ_UNKNOWN) begin
         pending_rsp.push_back(make_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1));
      end else if (c.idx != INDEX_ALL) begin
         pending_rsp.push_back(make_rsp(ST_NOT_ARRAY, 1'b0, 1'b0, '0, 1'b1));
      end else if (c.prio == DENIED_LEVEL) begin
         pending_rsp.push_back(make_rsp(ST_DENIED, 1'b0, 1'b0, '0, 1'b1));
      end else if (c.kind == REQ_WRITE && c.val >= 2) begin
         pending_rsp.push_back(make_rsp(ST_RANGE, 1'b0, 1'b0, '0, 1'b1));
      end else if (c.prio < 1 || c.prio > LEVELS) begin
         pending_rsp.push_back(make_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1));
      end else begin
         if (c.kind == REQ_WRITE) begin
            slot_value[lvl] = c.val[0];
            slot_held[lvl]  = 1'b1;
            if (lvl <= int'(active_slot)) begin
               active_slot = ACT_W'(lvl);
               present_bit = c.val[0];
            end
         end else begin
            slot_held[lvl] = 1'b0;
            if (lvl == int'(active_slot)) begin
               active_slot = ACT_W'(LEVELS);
               present_bit = fallback_bit;
               for (int i = lvl + 1; i < LEVELS; i++) begin
                  if (slot_held[i]) begin
                     active_slot = ACT_W'(i);
                     present_bit = slot_value[i];
                     break;
                  end
               end
            end
         end
         pending_rsp.push_back(make_rsp(ST_OK, prev != present_bit && !service_off,
            1'b0, '0, 1'b1));
      end
   endtask

   always @(posedge clock) begin
      array_rsp_t want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_present_value !== want.present)
               report_mismatch("present_value", rsp_present_value, want.present);
            if (rsp_changed !== want.changed)
               report_mismatch("changed", rsp_changed, want.changed);
            if (rsp_active_level !== want.active)
               report_mismatch("active_level", rsp_active_level, want.active);
            if (rsp_read_is_null !== want.is_null)
               report_mismatch("read_is_null", rsp_read_is_null, want.is_null);
            if (rsp_read_data !== want.data)
               report_mismatch("read_data", rsp_read_data, want.data);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   task automatic write_csr(input logic [ADDR_W-1:0] addr, input logic bit_value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_W'(bit_value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_FALLBACK_VALUE) begin
         fallback_bit = bit_value;
      end else begin
         service_off = bit_value;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_command(input command_t c, input bit typed, input array_rsp_t exp);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 34) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_type          <= c.kind;
      req_priority_req  <= c.prio;
      req_value         <= c.val;
      req_element_index <= c.idx;
      do @(posedge clock); while (busy);
      apply_command(c);
      if (typed) begin
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(exp);
      end
   endtask

   task automatic add_row(input logic [REQ_W-1:0] kind, input int prio, input int val,
                          input int idx, input bit typed, input status_type st,
                          input logic is_null, input int data);
      table_row_t row;
      row.cmd.kind    = kind;
      row.cmd.prio    = PRIO_W'(prio);
      row.cmd.val     = VALUE_W'(val);
      row.cmd.idx     = INDEX_W'(idx);
      row.typed       = typed;
      row.exp.status  = st;
      row.exp.present = 1'b0;
      row.exp.changed = 1'b0;
      row.exp.active  = ACT_W'(LEVELS);
      row.exp.is_null = is_null;
      row.exp.data    = DATA_W'(data);
      row.exp.last    = 1'b1;
      directed_rows.push_back(row);
   endtask

   function automatic command_t random_command();
      command_t c;
      int       r;
      r      = $urandom_range(99);
      c.kind = REQ_WRITE;
      c.prio = PRIO_W'($urandom_range(LEVELS, 1));
      c.val  = VALUE_W'($urandom_range(1, 0));
      c.idx  = INDEX_W'(INDEX_ALL);
      if (r < 40) begin
         c.kind = REQ_WRITE;
      end else if (r < 65) begin
         c.kind = REQ_RELINQUISH;
         c.val  = VALUE_W'($urandom);
      end else if (r < 75) begin
         c.kind = REQ_READ;
         c.prio = PRIO_W'($urandom);
         c.val  = VALUE_W'($urandom);
         c.idx  = INDEX_W'($urandom_range(LEVELS, 0));
      end else if (r < 80) begin
         c.kind = REQ_READ;
      end else begin
         c.kind = REQ_W'($urandom);
         c.prio = PRIO_W'($urandom);
         c.val  = VALUE_W'($urandom);
         c.idx  = INDEX_W'($urandom);
      end
      return c;
   endfunction

   task automatic drain_items();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      array_rsp_t none;
      logic       dflt_by_phase [PHASES];
      logic       oos_by_phase [PHASES];
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = REQ_WRITE;
      req_priority_req  = '0;
      req_value         = '0;
      req_element_index = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      mismatch_count    = 0;
      no_idle           = 1'b0;
      none              = '0;
      slot_held         = '0;
      active_slot       = ACT_W'(LEVELS);
      present_bit       = 1'b0;
      fallback_bit      = 1'b0;
      service_off       = 1'b0;
      for (int i = 0; i < LEVELS; i++) slot_value[i] = 1'b0;
      dflt_by_phase = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
      oos_by_phase  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

      add_row(REQ_READ, 0, 0, 0, 1, ST_OK, 1'b0, LEVELS);
      add_row(REQ_READ, 0, 0, 1, 1, ST_OK, 1'b1, 0);
      add_row(REQ_READ, 0, 0, 18, 1, ST_BAD_INDEX, 1'b0, 0);
      add_row(REQ_READ, 31, 255, 31, 1, ST_BAD_INDEX, 1'b0, 0);
      add_row(REQ_WRITE, 3, 1, 0, 1, ST_NOT_ARRAY, 1'b0, 0);
      add_row(REQ_RELINQUISH, 3, 0, 16, 1, ST_NOT_ARRAY, 1'b0, 0);
      add_row(REQ_WRITE, DENIED_LEVEL, 1, INDEX_ALL, 1, ST_DENIED, 1'b0, 0);
      add_row(REQ_RELINQUISH, DENIED_LEVEL, 0, INDEX_ALL, 1, ST_DENIED, 1'b0, 0);
      add_row(REQ_WRITE, 3, 255, INDEX_ALL, 1, ST_RANGE, 1'b0, 0);
      add_row(REQ_WRITE, 3, 2, INDEX_ALL, 1, ST_RANGE, 1'b0, 0);
      add_row(REQ_WRITE, 0, 1, INDEX_ALL, 1, ST_OK, 1'b0, 0);
      add_row(REQ_WRITE, 31, 1, INDEX_ALL, 1, ST_OK, 1'b0, 0);
      add_row(REQ_UNKNOWN, 31, 255, 31, 1, ST_OK, 1'b0, 0);
      add_row(REQ_WRITE, LEVELS, 1, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_WRITE, 1, 0, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_WRITE, 8, 1, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_READ, 0, 0, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_READ, 0, 0, 8, 0, ST_OK, 1'b0, 0);
      add_row(REQ_RELINQUISH, 1, 0, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_WRITE, 2, 1, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_RELINQUISH, LEVELS, 0, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_RELINQUISH, 2, 170, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_RELINQUISH, 8, 85, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_RELINQUISH, 17, 255, INDEX_ALL, 0, ST_OK, 1'b0, 0);
      add_row(REQ_READ, 0, 0, INDEX_ALL, 0, ST_OK, 1'b0, 0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         write_csr(ADDR_FALLBACK_VALUE, dflt_by_phase[p]);
         write_csr(ADDR_NOTIFY_OFF, oos_by_phase[p]);
         no_idle = (p == 2);
         if (p == 0) begin
            foreach (directed_rows[i])
               send_command(directed_rows[i].cmd, directed_rows[i].typed,
                            directed_rows[i].exp);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_command(random_command(), 1'b0, none);
         end
         @(negedge clock);
         start <= 1'b0;
         drain_items();
      end

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
